@@ rtl/datetime_to_epoch_count_macros.svh @@
// Assertion macros shared by the checker of the date to epoch count block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef DATETIME_TO_EPOCH_COUNT_MACROS_SVH
`define DATETIME_TO_EPOCH_COUNT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("datetime_to_epoch_count: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DTEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("datetime_to_epoch_count: assertion failed");

`endif

@@ rtl/dtec_pkg.sv @@
// Types, constants and small lookup functions for the date to epoch count block.
// Used by the top level and by the shared multiply-accumulate unit.
package dtec_pkg;

  localparam int COUNT_W = 40;
  localparam int YEAR_W  = 14;
  localparam int OPB_W   = 18;

  localparam logic [YEAR_W-1:0] EPOCH_RESET = 14'd1970;

  localparam logic REG_DAY_EPOCH    = 1'b0;
  localparam logic REG_SECOND_EPOCH = 1'b1;

  localparam logic signed [OPB_W-1:0] MUL_ONE      = 18'sd1;
  localparam logic signed [OPB_W-1:0] MUL_NEG_ONE  = -18'sd1;
  localparam logic signed [OPB_W-1:0] MUL_TEN      = 18'sd10;
  localparam logic signed [OPB_W-1:0] MUL_HOURS    = 18'sd24;
  localparam logic signed [OPB_W-1:0] MUL_SIXTY    = 18'sd60;
  localparam logic signed [OPB_W-1:0] MUL_HUNDRED  = 18'sd100;
  localparam logic signed [OPB_W-1:0] MUL_NEG_HUND = -18'sd100;
  localparam logic signed [OPB_W-1:0] MUL_YEAR     = 18'sd365;
  localparam logic signed [OPB_W-1:0] MUL_NEG_YEAR = -18'sd365;
  // 5243 / 2^19 gives an exact quotient by one hundred for any 14-bit value.
  localparam logic signed [OPB_W-1:0] MUL_RECIP100 = 18'sd5243;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [3:0] {
    STEP_YHI,
    STEP_YLO,
    STEP_YEAR,
    STEP_EDIV,
    STEP_EMOD,
    STEP_DBY,
    STEP_DBE,
    STEP_LPE,
    STEP_DOY,
    STEP_DAY,
    STEP_H0,
    STEP_H1,
    STEP_M0,
    STEP_M1,
    STEP_S0,
    STEP_S1
  } step_t;

  function automatic logic nib_bad(input logic [3:0] nib);
    return nib > 4'd9;
  endfunction

  // Days in the months before the given month of a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Leap days in the years before y, given y split into hundreds and remainder.
  function automatic logic [12:0] leaps(input logic [7:0] hi, input logic [6:0] lo,
                                        input logic [YEAR_W-1:0] y);
    logic [14:0] y3;
    logic [8:0]  c100;
    logic [9:0]  c3;
    y3   = {1'b0, y} + 15'd3;
    c100 = {1'b0, hi} + 9'(lo != 7'd0);
    c3   = {1'b0, c100} + 10'd3;
    return y3[14:2] - 13'(c100) + 13'(c3[9:2]);
  endfunction

endpackage

@@ rtl/dtec_mac.sv @@
// Shared multiply-accumulate unit of the date to epoch count block.
// Depends on dtec_pkg for operand widths.
module dtec_mac (
  input  logic signed [dtec_pkg::COUNT_W-1:0] op_a,
  input  logic signed [dtec_pkg::OPB_W-1:0]   op_b,
  input  logic signed [dtec_pkg::COUNT_W-1:0] op_c,
  output logic signed [dtec_pkg::COUNT_W-1:0] res
);

  logic signed [dtec_pkg::COUNT_W+dtec_pkg::OPB_W-1:0] prod;

  assign prod = op_a * op_b;
  assign res  = $signed(prod[dtec_pkg::COUNT_W-1:0] + op_c);

endmodule

@@ rtl/datetime_to_epoch_count.sv @@
// Top level of the date to epoch count block: sequencer, operand selection and registers.
// Depends on dtec_pkg and instantiates dtec_mac.
//
// Usage
// A request on the in_ channel carries a BCD date and time and a mode bit; it is taken
// at a clock edge with in_valid high and in_stall low. Mode 0 returns the zero-based day
// count since 1 January of the day epoch year, mode 1 the seconds since 1 January of the
// second epoch year. The cfg_ channel writes either epoch year and is always ready.
// A request runs the steps of the shared multiply-accumulate unit, one per cycle unless
// the last step waits on out_stall, up to the day step in days mode and up to the last
// seconds step in seconds mode; out_valid then rises, and only then is a request taken.
// The result sits in an output register, so a request may be accepted while the
// previous result is still held. If the receiver keeps out_stall high when a new result
// is ready, the sequencer waits on its last step and in_stall stays high.
// A bad digit the mode uses or a month over 13 gives format_error with a count of zero.
// Reset returns both epoch years to 1970 and empties the block.
module datetime_to_epoch_count (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [15:0]                      in_year_bcd,
  input  logic [7:0]                       in_month_bcd,
  input  logic [7:0]                       in_day_bcd,
  input  logic [7:0]                       in_hour_bcd,
  input  logic [7:0]                       in_minute_bcd,
  input  logic [7:0]                       in_second_bcd,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [dtec_pkg::COUNT_W-1:0] out_count,
  output logic                             out_format_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [dtec_pkg::YEAR_W-1:0]      cfg_data
);

  localparam int CW = dtec_pkg::COUNT_W;
  localparam int YW = dtec_pkg::YEAR_W;

  dtec_pkg::state_t state_r, state_nxt;
  dtec_pkg::step_t  step_r, step_nxt;

  logic [YW-1:0] day_epoch_r, second_epoch_r;
  logic [YW-1:0] epoch_r, epoch_nxt;
  logic          mode_r, mode_nxt;
  logic          err_r, err_nxt;
  logic [15:0]   ydig_r, ydig_nxt;
  logic [7:0]    mdig_r, mdig_nxt;
  logic [7:0]    ddig_r, ddig_nxt;
  logic [7:0]    hdig_r, hdig_nxt;
  logic [7:0]    ndig_r, ndig_nxt;
  logic [7:0]    sdig_r, sdig_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [6:0]    lo_r, lo_nxt;
  logic [YW-1:0] year_r, year_nxt;
  logic [7:0]    ehi_r, ehi_nxt;
  logic [6:0]    elo_r, elo_nxt;
  logic signed [CW-1:0] acc_r, acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_count_r, out_count_nxt;
  logic          out_err_r, out_err_nxt;

  logic signed [CW-1:0]            op_a, op_c, res;
  logic signed [dtec_pkg::OPB_W-1:0] op_b;

  logic          in_bad;
  logic [3:0]    month_idx;
  logic          year_leap;
  logic          leap_adj;
  logic          year_gt;
  logic [10:0]   doy_off;
  dtec_pkg::step_t last_step;
  logic          out_free;
  logic          advance;

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != dtec_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_count        = out_count_r;
  assign out_format_error = out_err_r;

  always_comb begin
    in_bad = dtec_pkg::nib_bad(in_year_bcd[15:12]) || dtec_pkg::nib_bad(in_year_bcd[11:8]) ||
             dtec_pkg::nib_bad(in_year_bcd[7:4])   || dtec_pkg::nib_bad(in_year_bcd[3:0])  ||
             dtec_pkg::nib_bad(in_month_bcd[7:4])  || dtec_pkg::nib_bad(in_month_bcd[3:0]) ||
             dtec_pkg::nib_bad(in_day_bcd[7:4])    || dtec_pkg::nib_bad(in_day_bcd[3:0])   ||
             (in_month_bcd[7:4] > 4'd1) ||
             ((in_month_bcd[7:4] == 4'd1) && (in_month_bcd[3:0] > 4'd3));
    if (in_mode) begin
      in_bad = in_bad ||
               dtec_pkg::nib_bad(in_hour_bcd[7:4])   || dtec_pkg::nib_bad(in_hour_bcd[3:0])   ||
               dtec_pkg::nib_bad(in_minute_bcd[7:4]) || dtec_pkg::nib_bad(in_minute_bcd[3:0]) ||
               dtec_pkg::nib_bad(in_second_bcd[7:4]) || dtec_pkg::nib_bad(in_second_bcd[3:0]);
    end
  end

  assign month_idx = (mdig_r[7:4] == 4'd1) ? 4'(4'd10 + mdig_r[3:0]) : mdig_r[3:0];
  assign year_leap = (lo_r == 7'd0) ? (hi_r[1:0] == 2'd0) : (lo_r[1:0] == 2'd0);
  assign leap_adj  = year_leap && (month_idx > 4'd2);
  assign year_gt   = year_r > epoch_r;
  assign doy_off   = 11'(ddig_r[3:0]) + 11'(dtec_pkg::cum_days(month_idx)) +
                     11'(leap_adj) - 11'd1;
  assign last_step = mode_r ? dtec_pkg::STEP_S1 : dtec_pkg::STEP_DAY;
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = (step_r != last_step) || out_free;

  always_comb begin
    op_a = '0;
    op_b = dtec_pkg::MUL_ONE;
    op_c = '0;
    case (step_r)
      dtec_pkg::STEP_YHI: begin
        op_a = {36'd0, ydig_r[15:12]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = {36'd0, ydig_r[11:8]};
      end
      dtec_pkg::STEP_YLO: begin
        op_a = {36'd0, ydig_r[7:4]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = {36'd0, ydig_r[3:0]};
      end
      dtec_pkg::STEP_YEAR: begin
        op_a = {32'd0, hi_r};
        op_b = dtec_pkg::MUL_HUNDRED;
        op_c = {33'd0, lo_r};
      end
      dtec_pkg::STEP_EDIV: begin
        op_a = {26'd0, epoch_r};
        op_b = dtec_pkg::MUL_RECIP100;
      end
      dtec_pkg::STEP_EMOD: begin
        op_a = {32'd0, ehi_r};
        op_b = dtec_pkg::MUL_NEG_HUND;
        op_c = {26'd0, epoch_r};
      end
      dtec_pkg::STEP_DBY: begin
        op_a = {26'd0, year_r};
        op_b = dtec_pkg::MUL_YEAR;
        op_c = {27'd0, dtec_pkg::leaps(hi_r, lo_r, year_r)};
      end
      dtec_pkg::STEP_DBE: begin
        op_a = {26'd0, epoch_r};
        op_b = dtec_pkg::MUL_NEG_YEAR;
        op_c = acc_r;
      end
      dtec_pkg::STEP_LPE: begin
        op_a = {27'd0, dtec_pkg::leaps(ehi_r, elo_r, epoch_r)};
        op_b = dtec_pkg::MUL_NEG_ONE;
        op_c = acc_r;
      end
      dtec_pkg::STEP_DOY: begin
        op_a = year_gt ? acc_r : '0;
        op_b = dtec_pkg::MUL_ONE;
        op_c = {{29{doy_off[10]}}, doy_off};
      end
      dtec_pkg::STEP_DAY: begin
        op_a = {36'd0, ddig_r[7:4]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = acc_r;
      end
      dtec_pkg::STEP_H0: begin
        op_a = acc_r;
        op_b = dtec_pkg::MUL_HOURS;
        op_c = {36'd0, hdig_r[3:0]};
      end
      dtec_pkg::STEP_H1: begin
        op_a = {36'd0, hdig_r[7:4]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = acc_r;
      end
      dtec_pkg::STEP_M0: begin
        op_a = acc_r;
        op_b = dtec_pkg::MUL_SIXTY;
        op_c = {36'd0, ndig_r[3:0]};
      end
      dtec_pkg::STEP_M1: begin
        op_a = {36'd0, ndig_r[7:4]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = acc_r;
      end
      dtec_pkg::STEP_S0: begin
        op_a = acc_r;
        op_b = dtec_pkg::MUL_SIXTY;
        op_c = {36'd0, sdig_r[3:0]};
      end
      dtec_pkg::STEP_S1: begin
        op_a = {36'd0, sdig_r[7:4]};
        op_b = dtec_pkg::MUL_TEN;
        op_c = acc_r;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  dtec_mac u_mac (
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .res  (res)
  );

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    epoch_nxt     = epoch_r;
    mode_nxt      = mode_r;
    err_nxt       = err_r;
    ydig_nxt      = ydig_r;
    mdig_nxt      = mdig_r;
    ddig_nxt      = ddig_r;
    hdig_nxt      = hdig_r;
    ndig_nxt      = ndig_r;
    sdig_nxt      = sdig_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    year_nxt      = year_r;
    ehi_nxt       = ehi_r;
    elo_nxt       = elo_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      dtec_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dtec_pkg::ST_RUN;
          step_nxt  = dtec_pkg::STEP_YHI;
          mode_nxt  = in_mode;
          err_nxt   = in_bad;
          epoch_nxt = in_mode ? second_epoch_r : day_epoch_r;
          ydig_nxt  = in_year_bcd;
          mdig_nxt  = in_month_bcd;
          ddig_nxt  = in_day_bcd;
          hdig_nxt  = in_hour_bcd;
          ndig_nxt  = in_minute_bcd;
          sdig_nxt  = in_second_bcd;
        end
      end
      dtec_pkg::ST_RUN: begin
        if (advance) begin
          case (step_r)
            dtec_pkg::STEP_YHI:  hi_nxt   = res[7:0];
            dtec_pkg::STEP_YLO:  lo_nxt   = res[6:0];
            dtec_pkg::STEP_YEAR: year_nxt = res[YW-1:0];
            dtec_pkg::STEP_EDIV: ehi_nxt  = res[dtec_pkg::RECIP_SHIFT+7:dtec_pkg::RECIP_SHIFT];
            dtec_pkg::STEP_EMOD: elo_nxt  = res[6:0];
            default:             acc_nxt  = res;
          endcase
          if (step_r == last_step) begin
            state_nxt     = dtec_pkg::ST_IDLE;
            out_valid_nxt = 1'b1;
            out_count_nxt = err_r ? '0 : res;
            out_err_nxt   = err_r;
          end else begin
            step_nxt = dtec_pkg::step_t'(step_r + 4'd1);
          end
        end
      end
      default: begin
        state_nxt = dtec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dtec_pkg::ST_IDLE;
      step_r         <= dtec_pkg::STEP_YHI;
      out_valid_r    <= 1'b0;
      day_epoch_r    <= dtec_pkg::EPOCH_RESET;
      second_epoch_r <= dtec_pkg::EPOCH_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dtec_pkg::REG_DAY_EPOCH) begin
          day_epoch_r <= cfg_data;
        end
        if (cfg_index == dtec_pkg::REG_SECOND_EPOCH) begin
          second_epoch_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    epoch_r     <= epoch_nxt;
    mode_r      <= mode_nxt;
    err_r       <= err_nxt;
    ydig_r      <= ydig_nxt;
    mdig_r      <= mdig_nxt;
    ddig_r      <= ddig_nxt;
    hdig_r      <= hdig_nxt;
    ndig_r      <= ndig_nxt;
    sdig_r      <= sdig_nxt;
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    year_r      <= year_nxt;
    ehi_r       <= ehi_nxt;
    elo_r       <= elo_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule

@@ rtl/dtec_checker.sv @@
// Port-level checker for the date to epoch count block, bound to the top level.
// Depends on dtec_pkg and the assertion macros header.
`include "datetime_to_epoch_count_macros.svh"

module dtec_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_mode,
  input logic [15:0]                      in_year_bcd,
  input logic [7:0]                       in_month_bcd,
  input logic [7:0]                       in_day_bcd,
  input logic [7:0]                       in_hour_bcd,
  input logic [7:0]                       in_minute_bcd,
  input logic [7:0]                       in_second_bcd,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [dtec_pkg::COUNT_W-1:0] out_count,
  input logic                             out_format_error,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic                             cfg_index,
  input logic [dtec_pkg::YEAR_W-1:0]      cfg_data
);

  // A held result must not change while the receiver stalls.
  `DTEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_count) && $stable(out_format_error))

  // A rejected request always reports a zero count.
  `DTEC_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_format_error, out_count == '0)

  // After a request is taken the block is busy.
  `DTEC_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)

  // A new result appears exactly as the block becomes free again.
  `DTEC_ASSERT_NOW(a_done_free, clk, rst_n, $rose(out_valid), !in_stall)

  // No count lies below one day of seconds before the epoch.
  `DTEC_ASSERT_NOW(a_range, clk, rst_n, out_valid, out_count >= -40'sd86400)

endmodule

bind datetime_to_epoch_count dtec_checker u_dtec_checker (.*);
